// ===== src/osd_pkg.sv =====
// Package for the orientation settling detector.
// Holds field widths, register indexes, reset values and shared types.
// No dependencies; osd_if, osd_minmax and the top level use it.
package osd_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 100;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned MAX_SAMPLE_W     = 32;
  localparam int unsigned FIELD_W          = 16;
  localparam int unsigned CFG_W            = 16;
  localparam int unsigned RUN_W            = 16;
  localparam int unsigned CFG_IDX_W        = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_COUNT    = 1'b1;

  localparam logic [CFG_W-1:0] RANGE_THRESHOLD_RST = 16'd41;
  localparam logic [CFG_W-1:0] SETTLE_COUNT_RST    = 16'd500;
  localparam logic [RUN_W-1:0] RUN_MAX             = '1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_e;

  typedef struct packed {
    logic seed;
    logic upd;
  } mm_ctl_t;

endpackage

// ===== src/osd_if.sv =====
// Channel interfaces of the orientation settling detector.
// Depends on osd_pkg for field widths.
interface osd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [osd_pkg::FIELD_W-1:0]  pitch_sample;
  logic signed [osd_pkg::FIELD_W-1:0]  roll_sample;
  logic                                link_error;
  modport source (output valid, pitch_sample, roll_sample, link_error, input ready);
  modport sink   (input valid, pitch_sample, roll_sample, link_error, output ready);
endinterface

interface osd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          data_good;
  logic [osd_pkg::RUN_W-1:0]     stable_run;
  modport source (output valid, data_good, stable_run, input ready);
  modport sink   (input valid, data_good, stable_run, output ready);
endinterface

interface osd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [osd_pkg::CFG_IDX_W-1:0]     index;
  logic [osd_pkg::CFG_W-1:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/osd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module osd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 100,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/osd_minmax.sv =====
// Running minimum and maximum tracker for one axis, with its range output.
// Depends on osd_pkg for the control struct and the default sample width.
module osd_minmax #(
  parameter int unsigned SW = osd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  osd_pkg::mm_ctl_t     ctl_i,
  input  logic signed [SW-1:0] seed_i,
  input  logic signed [SW-1:0] data_i,
  output logic [SW:0]          range_o
);

  logic signed [SW-1:0] lo_q;
  logic signed [SW-1:0] hi_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.seed) begin
      lo_q <= seed_i;
      hi_q <= seed_i;
    end else if (ctl_i.upd) begin
      if (data_i < lo_q) begin
        lo_q <= data_i;
      end
      if (data_i > hi_q) begin
        hi_q <= data_i;
      end
    end
  end

  assign range_o = {hi_q[SW-1], hi_q} - {lo_q[SW-1], lo_q};

endmodule

// ===== src/orientation_settling_detector_top.sv =====
// Orientation settling detector, top level. Depends on osd_pkg, osd_if, osd_ram, osd_minmax.
// Each item is decided after a scan of the filled part of the sample RAM at one entry per
// cycle, a wait state and a decide state; a settled item skips the scan and goes to decide.
// Items are taken one at a time; a waiting result stalls the next item.
// Reset: run counter and settled flag clear, registers take 41 and 500, and a fill count
// marks the windows empty so unwritten entries read as zero; no clearing pass is needed.
module orientation_settling_detector_top #(
  parameter int unsigned WINDOW_DEPTH = osd_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = osd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  osd_in_if.sink      in_i,
  osd_out_if.source   out_o,
  osd_cfg_if.sink     cfg_i
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned WD = WINDOW_DEPTH;
  localparam int unsigned AW = $clog2(WD);
  localparam int unsigned FW = $clog2(WD + 1);
  localparam int unsigned DW = 2 * SW;
  localparam int unsigned CW = (SW + 1 > osd_pkg::CFG_W) ? SW + 1 : osd_pkg::CFG_W;

  osd_pkg::state_e              state_q;
  logic [osd_pkg::CFG_W-1:0]    thr_q;
  logic [osd_pkg::CFG_W-1:0]    cnt_lim_q;
  logic [osd_pkg::RUN_W-1:0]    run_q;
  logic                         settled_q;
  logic [AW-1:0]                wptr_q;
  logic [FW-1:0]                fill_q;
  logic [FW-1:0]                scan_q;
  logic                         rd_vld_q;
  logic                         skip_q;
  logic                         out_valid_q;
  logic                         good_q;
  logic [osd_pkg::RUN_W-1:0]    orun_q;

  logic                                   in_fire;
  logic                                   eff_settled;
  logic signed [osd_pkg::MAX_SAMPLE_W-1:0] p_ext;
  logic signed [osd_pkg::MAX_SAMPLE_W-1:0] r_ext;
  logic signed [SW-1:0]                   p_smp;
  logic signed [SW-1:0]                   r_smp;
  logic [FW-1:0]                          fill_next;
  logic                                   full_next;
  logic [DW-1:0]                          rdata;
  osd_pkg::mm_ctl_t                       mm_ctl;
  logic signed [SW-1:0]                   p_seed;
  logic signed [SW-1:0]                   r_seed;
  logic [SW:0]                            p_range;
  logic [SW:0]                            r_range;
  logic                                   in_range;
  logic [osd_pkg::RUN_W-1:0]              run_d;
  logic                                   settled_d;
  logic                                   load_out;

  assign in_i.ready  = (state_q == osd_pkg::ST_IDLE);
  assign in_fire     = in_i.valid & in_i.ready;
  assign eff_settled = settled_q & ~in_i.link_error;

  assign p_ext = {
    {(osd_pkg::MAX_SAMPLE_W - osd_pkg::FIELD_W){in_i.pitch_sample[osd_pkg::FIELD_W-1]}},
    in_i.pitch_sample};
  assign r_ext = {
    {(osd_pkg::MAX_SAMPLE_W - osd_pkg::FIELD_W){in_i.roll_sample[osd_pkg::FIELD_W-1]}},
    in_i.roll_sample};
  assign p_smp = p_ext[SW-1:0];
  assign r_smp = r_ext[SW-1:0];

  assign fill_next = (fill_q == FW'(WD)) ? fill_q : fill_q + FW'(1);
  assign full_next = (fill_next == FW'(WD));

  osd_ram #(
    .WIDTH (DW),
    .DEPTH (WD)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire & ~eff_settled),
    .waddr_i (wptr_q),
    .wdata_i ({r_smp, p_smp}),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign mm_ctl.seed = in_fire & ~eff_settled;
  assign mm_ctl.upd  = rd_vld_q;
  assign p_seed      = full_next ? p_smp : '0;
  assign r_seed      = full_next ? r_smp : '0;

  osd_minmax #(.SW(SW)) u_pitch_mm (
    .clk_i   (clk_i),
    .ctl_i   (mm_ctl),
    .seed_i  (p_seed),
    .data_i  (rdata[SW-1:0]),
    .range_o (p_range)
  );

  osd_minmax #(.SW(SW)) u_roll_mm (
    .clk_i   (clk_i),
    .ctl_i   (mm_ctl),
    .seed_i  (r_seed),
    .data_i  (rdata[DW-1:SW]),
    .range_o (r_range)
  );

  assign in_range = (CW'(p_range) <= CW'(thr_q)) && (CW'(r_range) <= CW'(thr_q));

  always_comb begin
    if (skip_q) begin
      run_d = run_q;
    end else if (in_range) begin
      run_d = (run_q == osd_pkg::RUN_MAX) ? run_q : run_q + osd_pkg::RUN_W'(1);
    end else begin
      run_d = '0;
    end
    settled_d = settled_q | (run_d > cnt_lim_q);
  end

  assign load_out = (state_q == osd_pkg::ST_DECIDE) & (~out_valid_q | out_o.ready);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= osd_pkg::RANGE_THRESHOLD_RST;
      cnt_lim_q <= osd_pkg::SETTLE_COUNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        osd_pkg::CFG_RANGE_THRESHOLD: thr_q     <= cfg_i.data;
        osd_pkg::CFG_SETTLE_COUNT:    cnt_lim_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= osd_pkg::ST_IDLE;
      run_q       <= '0;
      settled_q   <= 1'b0;
      wptr_q      <= '0;
      fill_q      <= '0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      good_q      <= 1'b0;
      orun_q      <= '0;
    end else begin
      rd_vld_q <= (state_q == osd_pkg::ST_SCAN);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        osd_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (in_i.link_error) begin
              settled_q <= 1'b0;
              run_q     <= '0;
            end
            if (eff_settled) begin
              skip_q  <= 1'b1;
              state_q <= osd_pkg::ST_DECIDE;
            end else begin
              skip_q  <= 1'b0;
              wptr_q  <= (wptr_q == AW'(WD - 1)) ? '0 : wptr_q + AW'(1);
              fill_q  <= fill_next;
              scan_q  <= '0;
              state_q <= osd_pkg::ST_SCAN;
            end
          end
        end
        osd_pkg::ST_SCAN: begin
          scan_q <= scan_q + FW'(1);
          if (scan_q == fill_q - FW'(1)) begin
            state_q <= osd_pkg::ST_WAIT;
          end
        end
        osd_pkg::ST_WAIT: begin
          state_q <= osd_pkg::ST_DECIDE;
        end
        osd_pkg::ST_DECIDE: begin
          if (load_out) begin
            run_q     <= run_d;
            settled_q <= settled_d;
            good_q    <= settled_d;
            orun_q    <= run_d;
            state_q   <= osd_pkg::ST_IDLE;
          end
        end
        default: begin
          state_q <= osd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.data_good  = good_q;
  assign out_o.stable_run = orun_q;

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == osd_pkg::ST_SCAN) |-> (scan_q < fill_q))
    else $error("Window scan address ran past the fill count.");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WD))
    else $error("Fill count exceeds the window depth.");

  a_settled_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled_q |-> (run_q != '0))
    else $error("Settled flag is set with an empty run.");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("Input taken again while a transaction is in progress.");

endmodule
